// ===== rtl/reader_writer_lock_with_wait_queue_defines.svh =====
// assertion macros for the reader-writer lock checker
`ifndef READER_WRITER_LOCK_WITH_WAIT_QUEUE_DEFINES_SVH
`define READER_WRITER_LOCK_WITH_WAIT_QUEUE_DEFINES_SVH

// property checked only while out of reset
`define RWLQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define RWLQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/rwl_pkg.sv =====
// shared constants, codes and types of the reader-writer lock
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_READERS = 255;
    localparam int ID_W        = 8;
    localparam int CNT_W       = 8;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ACT_READ_LOCK    = 2'd0,
        ACT_READ_UNLOCK  = 2'd1,
        ACT_WRITE_LOCK   = 2'd2,
        ACT_WRITE_UNLOCK = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_GRANTED      = 3'd0,
        ST_QUEUED       = 3'd1,
        ST_RELEASED     = 3'd2,
        ST_QUEUE_FULL   = 3'd3,
        ST_READER_LIMIT = 3'd4,
        ST_MISMATCH     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MODE_FREE    = 2'd0,
        MODE_READING = 2'd1,
        MODE_WRITING = 2'd2
    } t_mode;

    typedef enum logic {
        KIND_ANSWER = 1'b0,
        KIND_WAKE   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_GE  = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [CNT_W-1:0]   a;
        logic [CNT_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [CNT_W-1:0]   res;
        logic               ge;
        logic               zero;
    } t_alu_rsp;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_CHECK   = 3'd1,
        S_APPLY   = 3'd2,
        S_ANSWER  = 3'd3,
        S_WAKE_RD = 3'd4,
        S_WAKE    = 3'd5
    } t_state;

endpackage

// ===== rtl/rwl_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps

interface rwl_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [rwl_pkg::ID_W-1:0]   requester_id;

    modport source (output valid, output action, output requester_id, input ready);
    modport sink   (input valid, input action, input requester_id, output ready);
endinterface

interface rwl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [2:0]                 status;
    logic [rwl_pkg::ID_W-1:0]   task_id;
    logic [1:0]                 lock_state;
    logic [rwl_pkg::CNT_W-1:0]  readers_now;
    logic                       last;

    modport source (output valid, output kind, output status, output task_id,
                    output lock_state, output readers_now, output last, input ready);
    modport sink   (input valid, input kind, input status, input task_id,
                    input lock_state, input readers_now, input last, output ready);
endinterface

// ===== rtl/reader_writer_lock_with_wait_queue.sv =====
// top level: reader-writer lock sequencer with wait queue
`timescale 1ns / 1ps

// Reader-writer lock. One request per transfer on i_req: action (read lock,
// read unlock, write lock, write unlock) and a requester id. Results leave on
// o_rsp, each with kind, status, task id, lock state and reader count after
// the request, and last set on the final result of that request.
// A request that frees the lock gets its answer (released) and then one wake
// result per queued waiter, oldest first; the queue ends up empty.
// Sequence: the request is taken in the idle cycle, checked in the next and
// applied in the one after; the answer is then shown from S_ANSWER. Each
// wake is a queue read (S_WAKE_RD), then the wake result (S_WAKE). The
// shared add/compare unit and the registered queue read set this order.
// i_req.ready is high only while idle: one request is worked on at a time.
// If the receiver holds o_rsp.ready low the result stays valid and unchanged
// and the sequencer waits. Synchronous reset (i_rst_n low) frees the lock,
// clears the reader count and empties the queue; no output is valid after.

module reader_writer_lock_with_wait_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwl_req_if.sink    i_req,
    rwl_rsp_if.source  o_rsp
);

    rwl_pkg::t_state                r_state, n_state;
    rwl_pkg::t_action               r_action;
    logic [rwl_pkg::ID_W-1:0]       r_id;
    rwl_pkg::t_mode                 r_mode, n_mode;
    logic [rwl_pkg::CNT_W-1:0]      r_readers, n_readers;
    rwl_pkg::t_status               r_status, n_status;
    logic                           r_last, n_last;
    logic                           r_flag;

    rwl_pkg::t_alu_req              w_alu_req;
    rwl_pkg::t_alu_rsp              w_alu_rsp;
    rwl_pkg::t_fifo_ctl             w_fifo_ctl;
    logic [rwl_pkg::ID_W-1:0]       w_wake_id;
    logic [rwl_pkg::FILL_W-1:0]     w_fill;
    logic [rwl_pkg::CNT_W-1:0]      w_fill_ext;
    logic                           w_to_queue;

    rwl_alu u_alu (
        .i_op  (w_alu_req),
        .o_res (w_alu_rsp)
    );

    rwl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fifo_ctl),
        .i_wr_id (r_id),
        .o_rd_id (w_wake_id),
        .o_fill  (w_fill)
    );

    assign w_fill_ext = rwl_pkg::CNT_W'(w_fill);
    // lock requests that cannot be granted in the current mode
    assign w_to_queue = (r_action == rwl_pkg::ACT_WRITE_LOCK && r_mode != rwl_pkg::MODE_FREE) ||
                        (r_action == rwl_pkg::ACT_READ_LOCK && r_mode == rwl_pkg::MODE_WRITING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rwl_pkg::S_IDLE;
            r_mode    <= rwl_pkg::MODE_FREE;
            r_readers <= '0;
            r_last    <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_readers <= n_readers;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rwl_pkg::S_IDLE && i_req.valid) begin
            r_action <= rwl_pkg::t_action'(i_req.action);
            r_id     <= i_req.requester_id;
        end
        if (r_state == rwl_pkg::S_CHECK) begin
            r_flag <= w_alu_rsp.ge;
        end
        r_status <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_readers  = r_readers;
        n_status   = r_status;
        n_last     = r_last;
        w_fifo_ctl = '0;
        w_alu_req  = '{op: rwl_pkg::ALU_GE, a: r_readers,
                       b: rwl_pkg::CNT_W'(rwl_pkg::MAX_READERS)};

        case (r_state)
            rwl_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = rwl_pkg::S_CHECK;
                end
            end
            rwl_pkg::S_CHECK: begin
                // queue full check for waiters, reader limit otherwise
                if (w_to_queue) begin
                    w_alu_req = '{op: rwl_pkg::ALU_GE, a: w_fill_ext,
                                  b: rwl_pkg::CNT_W'(rwl_pkg::QUEUE_DEPTH)};
                end
                n_state = rwl_pkg::S_APPLY;
            end
            rwl_pkg::S_APPLY: begin
                n_last  = 1'b1;
                n_state = rwl_pkg::S_ANSWER;
                w_alu_req = '{op: (r_action == rwl_pkg::ACT_READ_UNLOCK) ?
                                  rwl_pkg::ALU_SUB : rwl_pkg::ALU_ADD,
                              a: r_readers, b: rwl_pkg::CNT_W'(1)};
                if (w_to_queue) begin
                    if (r_flag) begin
                        n_status = rwl_pkg::ST_QUEUE_FULL;
                    end else begin
                        n_status = rwl_pkg::ST_QUEUED;
                        w_fifo_ctl.push = 1'b1;
                    end
                end else begin
                    case (r_action)
                        rwl_pkg::ACT_READ_LOCK: begin
                            if (r_flag) begin
                                n_status = rwl_pkg::ST_READER_LIMIT;
                            end else begin
                                n_status  = rwl_pkg::ST_GRANTED;
                                n_readers = w_alu_rsp.res;
                                n_mode    = rwl_pkg::MODE_READING;
                            end
                        end
                        rwl_pkg::ACT_READ_UNLOCK: begin
                            if (r_mode != rwl_pkg::MODE_READING || r_readers == '0) begin
                                n_status = rwl_pkg::ST_MISMATCH;
                            end else begin
                                n_status  = rwl_pkg::ST_RELEASED;
                                n_readers = w_alu_rsp.res;
                                if (w_alu_rsp.zero) begin
                                    n_mode = rwl_pkg::MODE_FREE;
                                    n_last = (w_fill == '0);
                                end
                            end
                        end
                        rwl_pkg::ACT_WRITE_LOCK: begin
                            n_status = rwl_pkg::ST_GRANTED;
                            n_mode   = rwl_pkg::MODE_WRITING;
                        end
                        rwl_pkg::ACT_WRITE_UNLOCK: begin
                            if (r_mode != rwl_pkg::MODE_WRITING) begin
                                n_status = rwl_pkg::ST_MISMATCH;
                            end else begin
                                n_status  = rwl_pkg::ST_RELEASED;
                                n_mode    = rwl_pkg::MODE_FREE;
                                n_readers = '0;
                                n_last    = (w_fill == '0);
                            end
                        end
                        default: n_status = rwl_pkg::ST_MISMATCH;
                    endcase
                end
            end
            rwl_pkg::S_ANSWER: begin
                if (o_rsp.ready) begin
                    n_state = r_last ? rwl_pkg::S_IDLE : rwl_pkg::S_WAKE_RD;
                end
            end
            rwl_pkg::S_WAKE_RD: begin
                w_fifo_ctl.pop = 1'b1;
                n_state = rwl_pkg::S_WAKE;
            end
            rwl_pkg::S_WAKE: begin
                if (o_rsp.ready) begin
                    n_state = (w_fill == '0) ? rwl_pkg::S_IDLE : rwl_pkg::S_WAKE_RD;
                end
            end
            default: n_state = rwl_pkg::S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == rwl_pkg::S_IDLE);

    assign o_rsp.valid       = (r_state == rwl_pkg::S_ANSWER) || (r_state == rwl_pkg::S_WAKE);
    assign o_rsp.kind        = (r_state == rwl_pkg::S_WAKE) ? rwl_pkg::KIND_WAKE
                                                            : rwl_pkg::KIND_ANSWER;
    assign o_rsp.status      = (r_state == rwl_pkg::S_WAKE) ? rwl_pkg::ST_GRANTED : r_status;
    assign o_rsp.task_id     = (r_state == rwl_pkg::S_WAKE) ? w_wake_id : r_id;
    assign o_rsp.lock_state  = r_mode;
    assign o_rsp.readers_now = r_readers;
    assign o_rsp.last        = (r_state == rwl_pkg::S_WAKE) ? (w_fill == '0) : r_last;

endmodule

// ===== rtl/rwl_alu.sv =====
// shared add / subtract / compare unit used by the sequencer
`timescale 1ns / 1ps

module rwl_alu (
    input  rwl_pkg::t_alu_req i_op,
    output rwl_pkg::t_alu_rsp o_res
);

    logic [rwl_pkg::CNT_W:0]   w_diff;
    logic [rwl_pkg::CNT_W-1:0] w_sum;
    logic [rwl_pkg::CNT_W-1:0] w_res;

    // one subtractor gives both the difference and the compare
    assign w_diff = {1'b0, i_op.a} - {1'b0, i_op.b};
    assign w_sum  = i_op.a + i_op.b;

    always_comb begin
        case (i_op.op)
            rwl_pkg::ALU_ADD: w_res = w_sum;
            rwl_pkg::ALU_SUB: w_res = w_diff[rwl_pkg::CNT_W-1:0];
            rwl_pkg::ALU_GE:  w_res = i_op.a;
            default:          w_res = i_op.a;
        endcase
    end

    assign o_res.res  = w_res;
    assign o_res.ge   = ~w_diff[rwl_pkg::CNT_W];
    assign o_res.zero = (w_res == '0);

endmodule

// ===== rtl/rwl_fifo.sv =====
// circular wait queue of requester ids with registered read
`timescale 1ns / 1ps

module rwl_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rwl_pkg::t_fifo_ctl          i_ctl,
    input  logic [rwl_pkg::ID_W-1:0]    i_wr_id,
    output logic [rwl_pkg::ID_W-1:0]    o_rd_id,
    output logic [rwl_pkg::FILL_W-1:0]  o_fill
);

    logic [rwl_pkg::ID_W-1:0]   r_mem [rwl_pkg::QUEUE_DEPTH];
    logic [rwl_pkg::PTR_W-1:0]  r_head;
    logic [rwl_pkg::FILL_W-1:0] r_fill;
    logic [rwl_pkg::ID_W-1:0]   r_rd_id;
    logic [rwl_pkg::FILL_W:0]   w_slot_sum;
    logic [rwl_pkg::FILL_W:0]   w_slot;
    logic [rwl_pkg::PTR_W-1:0]  n_head;

    // tail slot wraps at the queue depth
    assign w_slot_sum = (rwl_pkg::FILL_W+1)'(r_head) + (rwl_pkg::FILL_W+1)'(r_fill);
    assign w_slot = (w_slot_sum >= (rwl_pkg::FILL_W+1)'(rwl_pkg::QUEUE_DEPTH)) ?
                    w_slot_sum - (rwl_pkg::FILL_W+1)'(rwl_pkg::QUEUE_DEPTH) : w_slot_sum;
    assign n_head = (r_head == rwl_pkg::PTR_W'(rwl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_slot[rwl_pkg::PTR_W-1:0]] <= i_wr_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rd_id <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_ctl.push) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_ctl.pop) begin
            r_head <= n_head;
            r_fill <= r_fill - 1'b1;
        end
    end

    assign o_rd_id = r_rd_id;
    assign o_fill  = r_fill;

endmodule

// ===== rtl/rwl_checker.sv =====
// port-level checker for the reader-writer lock, bound to the top level
`timescale 1ns / 1ps
`include "reader_writer_lock_with_wait_queue_defines.svh"

module rwl_port_props (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_kind,
    input logic [2:0]                   i_status,
    input logic [1:0]                   i_lock_state,
    input logic [rwl_pkg::CNT_W-1:0]    i_readers_now,
    input logic                         i_last
);

    // nothing is shown right after reset
    `RWLQ_ASSERT_ALWAYS(a_quiet_after_reset, $past(!i_rst_n) |-> !i_rsp_valid, "result valid after reset")

    // a new request is never taken while a result is pending
    `RWLQ_ASSERT(a_one_at_a_time, !(i_req_ready && i_rsp_valid), "ready while result pending")

    // wakes only follow a release, so they see a free lock
    `RWLQ_ASSERT(a_wake_fields, (i_rsp_valid && i_kind) |-> (i_status == rwl_pkg::ST_GRANTED && i_lock_state == rwl_pkg::MODE_FREE && i_readers_now == '0), "bad wake result")

    // only a release answer can be followed by wakes
    `RWLQ_ASSERT(a_answer_last, (i_rsp_valid && !i_kind && i_status != rwl_pkg::ST_RELEASED) |-> i_last, "answer without last")

endmodule

bind reader_writer_lock_with_wait_queue rwl_port_props u_rwl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_kind        (o_rsp.kind),
    .i_status      (o_rsp.status),
    .i_lock_state  (o_rsp.lock_state),
    .i_readers_now (o_rsp.readers_now),
    .i_last        (o_rsp.last)
);
